[hw/rtl/rtavg_pkg.sv]
// ----------------------------------------------------------------------------
// rtavg_pkg
// Shared constants for the ratiometric temperature averager: result widths,
// fixed-point scale of the temperature quotient and result field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rtavg_pkg;

  // Width of one temperature result, signed sixteenths of a degree
  localparam int unsigned TEMP_W      = 15;
  // Quotient bits formed by the divider; the top step only flags overflow
  localparam int unsigned Q_W         = 16;
  // 4000*s/r rounded half up is floor((SCALE*s + r) / (2*r))
  localparam int unsigned SCALE       = 8000;
  // Quotient ceiling and offset to degrees (in sixteenths)
  localparam int unsigned TEMP_MAX_Q  = 20000;
  localparam int unsigned TEMP_OFFSET = 4000;
  localparam int          TEMP_LO     = -4000;
  localparam int          TEMP_HI     = 16000;

  // Result word: ready_res, running, temp_average, temp_latest, ref_zero
  localparam int unsigned OUT_BITS = 3 + 2 * TEMP_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

[hw/rtl/rtavg_ram.sv]
// ----------------------------------------------------------------------------
// rtavg_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rtavg_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/ratiometric_adc_averager_unit.sv]
// Flow: a start request or a sample that does not end a round passes through
//   ST_DONE to the result register; a sample that closes a round passes through
//   ST_READ (ring read), two 16-step divisions on one divider, then ST_DONE.
// Requests: one at a time; the next is taken once the result is posted and the
//   unit is back in ST_IDLE, later while the result waits.
// Reset: control state, ring valid bits, sums and results clear at once.
// ----------------------------------------------------------------------------
// ratiometric_adc_averager_unit
// Collects ADC rounds of sensor and reference channels into a ring RAM,
// keeps ring sums and forms averaged and latest ratiometric temperatures.
// ----------------------------------------------------------------------------
`default_nettype none

module ratiometric_adc_averager_unit #(
  parameter int unsigned RING_DEPTH         = 8,
  parameter int unsigned CHANNELS_PER_ROUND = 3,
  parameter int unsigned SAMPLE_BITS        = 12,
  localparam int unsigned IN_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write: continuous
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_data_i,
  // Input request
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [IN_W-1:0]              s_axis_tdata,  // sample
  input  wire logic                         s_axis_tuser,  // mode
  // Result
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // ready_res, running, temp_average, temp_latest, ref_zero
  output logic [rtavg_pkg::OUT_W-1:0]       m_axis_tdata
);

  import rtavg_pkg::*;

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CP_W  = (CHANNELS_PER_ROUND > 1) ? $clog2(CHANNELS_PER_ROUND) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
  localparam int unsigned DIV_W = SUM_W + Q_W;
  localparam int unsigned CNT_W = $clog2(Q_W);
  localparam int unsigned ENT_W = 2 * SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]               state_q, state_d;
  logic                     cont_q, cont_d;
  logic [CP_W-1:0]          chan_q, chan_d;
  logic [SAMPLE_BITS-1:0]   pend_s_q, pend_s_d;
  logic [SAMPLE_BITS-1:0]   pend_r_q, pend_r_d;
  logic [IDX_W-1:0]         ring_idx_q, ring_idx_d;
  logic [RING_DEPTH-1:0]    ent_vld_q, ent_vld_d;
  logic [SUM_W-1:0]         ssum_q, ssum_d;
  logic [SUM_W-1:0]         rsum_q, rsum_d;
  logic                     ready_q, ready_d;
  logic                     run_q, run_d;
  logic signed [TEMP_W-1:0] avg_q, avg_d;
  logic signed [TEMP_W-1:0] lat_q, lat_d;
  logic                     zero_q, zero_d;
  logic                     pass_q, pass_d;
  logic [DIV_W-1:0]         rem_q, rem_d;
  logic [DIV_W-1:0]         dsh_q, dsh_d;
  logic [Q_W-1:0]           quo_q, quo_d;
  logic                     sat_q, sat_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     m_valid_q, m_valid_d;
  logic [OUT_W-1:0]         m_data_q, m_data_d;

  logic                     in_req;
  logic                     in_mode;
  logic [SAMPLE_BITS-1:0]   in_smp;
  logic                     ram_we;
  logic [ENT_W-1:0]         ram_rdata;
  logic [ENT_W-1:0]         old_ent;
  logic [SUM_W-1:0]         s_sel, r_sel;
  logic                     div_ge;
  logic [Q_W-1:0]           q_clamp;
  logic signed [Q_W:0]      temp_full;
  logic [OUT_BITS-1:0]      res_bits;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser;
  assign in_smp        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Ring RAM: sensor in the low half, reference in the high half
  rtavg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ring_idx_q),
    .wdata_i ({pend_r_q, pend_s_q}),
    .raddr_i (ring_idx_q),
    .rdata_o (ram_rdata)
  );

  assign ram_we  = (state_q == ST_READ);
  // An entry never written since reset reads as zero
  assign old_ent = ent_vld_q[ring_idx_q] ? ram_rdata : '0;

  // Divider operands: ring sums on the first pass, latest pair on the second
  assign s_sel = pass_q ? SUM_W'(pend_s_q) : ssum_q;
  assign r_sel = pass_q ? SUM_W'(pend_r_q) : rsum_q;

  // Restoring step and final clamp
  assign div_ge    = (rem_q >= dsh_q);
  assign q_clamp   = (sat_q || (quo_q > Q_W'(TEMP_MAX_Q))) ? Q_W'(TEMP_MAX_Q) : quo_q;
  assign temp_full = $signed({1'b0, q_clamp}) - $signed((Q_W + 1)'(TEMP_OFFSET));

  assign res_bits = {zero_q, lat_q, avg_q, run_q, ready_q};

  // Next-state logic
  always_comb begin
    state_d    = state_q;
    cont_d     = cont_q;
    chan_d     = chan_q;
    pend_s_d   = pend_s_q;
    pend_r_d   = pend_r_q;
    ring_idx_d = ring_idx_q;
    ent_vld_d  = ent_vld_q;
    ssum_d     = ssum_q;
    rsum_d     = rsum_q;
    ready_d    = ready_q;
    run_d      = run_q;
    avg_d      = avg_q;
    lat_d      = lat_q;
    zero_d     = zero_q;
    pass_d     = pass_q;
    rem_d      = rem_q;
    dsh_d      = dsh_q;
    quo_d      = quo_q;
    sat_d      = sat_q;
    cnt_d      = cnt_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;

    if (cfg_valid_i) begin
      cont_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          state_d = ST_DONE;
          if (in_mode) begin
            // Start request: arm the block
            if (!cont_q) begin
              ready_d = 1'b0;
            end else begin
              ring_idx_d = '0;
            end
            run_d = 1'b1;
          end else if (run_q) begin
            if (chan_q == CP_W'(0)) begin
              pend_s_d = in_smp;
            end
            if (chan_q == CP_W'(1)) begin
              pend_r_d = in_smp;
            end
            if (chan_q == CP_W'(CHANNELS_PER_ROUND - 1)) begin
              // Round complete: fetch the slot being replaced
              chan_d  = '0;
              state_d = ST_READ;
            end else begin
              chan_d = chan_q + CP_W'(1);
            end
          end
        end
      end

      ST_READ: begin
        // Replace the slot, update sums and advance the ring
        ssum_d = ssum_q - SUM_W'(old_ent[SAMPLE_BITS-1:0]) + SUM_W'(pend_s_q);
        rsum_d = rsum_q - SUM_W'(old_ent[ENT_W-1:SAMPLE_BITS]) + SUM_W'(pend_r_q);
        ent_vld_d[ring_idx_q] = 1'b1;
        if (ring_idx_q == IDX_W'(RING_DEPTH - 1)) begin
          ring_idx_d = '0;
        end else begin
          ring_idx_d = ring_idx_q + IDX_W'(1);
        end
        if (cont_q) begin
          if (ring_idx_q == IDX_W'(RING_DEPTH - 1)) begin
            ready_d = 1'b1;
          end
        end else begin
          ready_d = 1'b1;
          run_d   = 1'b0;
        end
        zero_d  = 1'b0;
        pass_d  = 1'b0;
        state_d = ST_SETUP;
      end

      ST_SETUP: begin
        // Load numerator SCALE*s + r and divisor 2r aligned to the top step
        rem_d   = DIV_W'(s_sel) * DIV_W'(SCALE) + DIV_W'(r_sel);
        dsh_d   = DIV_W'(r_sel) << Q_W;
        quo_d   = '0;
        sat_d   = 1'b0;
        cnt_d   = '0;
        zero_d  = zero_q || (r_sel == '0);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        // One quotient bit per cycle; the top bit marks overflow only
        if (cnt_q == '0) begin
          sat_d = div_ge;
        end
        if (div_ge) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = {quo_q[Q_W-2:0], div_ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!pass_q) begin
          avg_d   = TEMP_W'(temp_full);
          pass_d  = 1'b1;
          state_d = ST_SETUP;
        end else begin
          lat_d   = TEMP_W'(temp_full);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free, then post the result
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'(res_bits);
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cont_q     <= 1'b0;
      chan_q     <= '0;
      pend_s_q   <= '0;
      pend_r_q   <= '0;
      ring_idx_q <= '0;
      ent_vld_q  <= '0;
      ssum_q     <= '0;
      rsum_q     <= '0;
      ready_q    <= 1'b0;
      run_q      <= 1'b0;
      avg_q      <= '0;
      lat_q      <= '0;
      zero_q     <= 1'b0;
      pass_q     <= 1'b0;
      cnt_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cont_q     <= cont_d;
      chan_q     <= chan_d;
      pend_s_q   <= pend_s_d;
      pend_r_q   <= pend_r_d;
      ring_idx_q <= ring_idx_d;
      ent_vld_q  <= ent_vld_d;
      ssum_q     <= ssum_d;
      rsum_q     <= rsum_d;
      ready_q    <= ready_d;
      run_q      <= run_d;
      avg_q      <= avg_d;
      lat_q      <= lat_d;
      zero_q     <= zero_d;
      pass_q     <= pass_d;
      cnt_q      <= cnt_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Divider datapath and result payload
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    quo_q    <= quo_d;
    sat_q    <= sat_d;
    m_data_q <= m_data_d;
  end

  // Posting a result always leaves a valid result behind
  a_post_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && (!m_valid_q || m_axis_tready) |=> m_valid_q)
    else $error("result posted but output not valid");

  // Running only drops at the close of a single-mode round
  a_run_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(run_q) |-> ($past(state_q) == ST_READ) && !$past(cont_q))
    else $error("running cleared outside a round close");

  // Ring index stays inside the ring
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ring_idx_q) < int'(RING_DEPTH))
    else $error("ring index out of range");

  // Stored temperatures stay within the saturation limits
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(avg_q) >= TEMP_LO) && (int'(avg_q) <= TEMP_HI) &&
    (int'(lat_q) >= TEMP_LO) && (int'(lat_q) <= TEMP_HI))
    else $error("temperature out of range");

  // A new request is only taken with the divider at rest
  a_req_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> (state_q == ST_DONE) || (state_q == ST_READ))
    else $error("request accepted while busy");

endmodule

`default_nettype wire
